// File: sv/iff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types, codes and helpers of the integer field formatter.
// ----------------------------------------------------------------------------
package iff_pkg;

	// Radix codes of the input item; any other code is taken as hexadecimal
	localparam logic [1:0] RADIX_OCT = 2'd0;
	localparam logic [1:0] RADIX_DEC = 2'd1;
	localparam logic [1:0] RADIX_HEX = 2'd2;

	// Width of the length counters of the field
	localparam int CNT_W = 8;

	// Segments of a field, in the order they are sent
	localparam int SEG_N = 6;
	localparam logic [2:0] SEG_LEAD   = 3'd0;
	localparam logic [2:0] SEG_SIGN   = 3'd1;
	localparam logic [2:0] SEG_PREFIX = 3'd2;
	localparam logic [2:0] SEG_ZERO   = 3'd3;
	localparam logic [2:0] SEG_DIGIT  = 3'd4;
	localparam logic [2:0] SEG_TRAIL  = 3'd5;

	// ASCII characters
	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_A_UP  = 8'h41;

	// Commands from the sequencer to the digit converter
	typedef struct packed {
		logic start;
		logic pop;
	} conv_ctrl_t;

	// Status of the digit converter
	typedef struct packed {
		logic       done;
		logic [3:0] top_digit;
	} conv_stat_t;

	// Map a digit value to its ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else if (upper) begin
			c = CH_A_UP + {4'd0, d} - 8'd10;
		end else begin
			c = CH_A_LO + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: sv/iff_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_item_if
// Input channel: one integer conversion request per transaction.
// ----------------------------------------------------------------------------
interface iff_item_if;
	logic        valid;
	logic        ready;
	logic [63:0] magnitude;
	logic        is_negative;
	logic [1:0]  radix_select;
	logic        upper_case;
	logic        align_left;
	logic        pad_zero;
	logic        plus_sign;
	logic        blank_sign;
	logic [6:0]  field_width;
	logic [5:0]  min_digits;
	logic        precision_given;
	logic        alt_form;

	modport source (
		output valid, magnitude, is_negative, radix_select, upper_case, align_left,
			pad_zero, plus_sign, blank_sign, field_width, min_digits, precision_given,
			alt_form,
		input  ready
	);

	modport sink (
		input  valid, magnitude, is_negative, radix_select, upper_case, align_left,
			pad_zero, plus_sign, blank_sign, field_width, min_digits, precision_given,
			alt_form,
		output ready
	);
endinterface
`default_nettype wire

// File: sv/iff_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_result_if
// Output channel: one character of the formatted field per transaction.
// ----------------------------------------------------------------------------
interface iff_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (
		output valid, out_char, last_char,
		input  ready
	);

	modport sink (
		input  valid, out_char, last_char,
		output ready
	);
endinterface
`default_nettype wire

// File: sv/iff_digit_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_digit_conv
// Bit-serial radix converter: shifts the value in one bit per cycle into a
// chain of digit slots (shift-and-add-3 for decimal), then drops leading zero
// digits and hands the digits out most significant first.
// ----------------------------------------------------------------------------
module iff_digit_conv #(
	parameter int VALUE_BITS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire iff_pkg::conv_ctrl_t     ctrl,
	input  wire [VALUE_BITS-1:0]         value,
	input  wire [1:0]                    radix,
	output iff_pkg::conv_stat_t          stat,
	output logic [$clog2((VALUE_BITS+2)/3+1)-1:0] ndig
);

	localparam int NDIG = (VALUE_BITS + 2) / 3;
	localparam int NW   = $clog2(NDIG + 1);
	localparam int BW   = $clog2(VALUE_BITS + 1);

	typedef enum logic [3:0] {
		C_IDLE  = 4'b0001,
		C_SHIFT = 4'b0010,
		C_NORM  = 4'b0100,
		C_DONE  = 4'b1000
	} conv_phase_t;

	conv_phase_t           phase_q;
	logic [BW-1:0]         bits_q;
	logic [NW-1:0]         ndig_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [1:0]            radix_q;
	logic [3:0]            slot_q [NDIG];
	logic [3:0]            corr   [NDIG];
	logic [3:0]            shifted[NDIG];
	logic [NDIG-1:0]       carry;
	logic                  norm_shift;

	// Correct and shift the digit chain by one bit
	always_comb begin
		carry[0] = value_q[VALUE_BITS-1];
		for (int i = 0; i < NDIG; i++) begin
			if (radix_q == iff_pkg::RADIX_DEC && slot_q[i] >= 4'd5) begin
				corr[i] = slot_q[i] + 4'd3;
			end else begin
				corr[i] = slot_q[i];
			end
			if (radix_q == iff_pkg::RADIX_OCT) begin
				shifted[i] = {1'b0, corr[i][1:0], carry[i]};
				if (i < NDIG - 1) begin
					carry[i+1] = corr[i][2];
				end
			end else begin
				shifted[i] = {corr[i][2:0], carry[i]};
				if (i < NDIG - 1) begin
					carry[i+1] = corr[i][3];
				end
			end
		end
	end

	// Drop a leading zero digit while more than one remains
	assign norm_shift = (phase_q == C_NORM) && (ndig_q > NW'(1))
		&& (slot_q[NDIG-1] == 4'd0);

	// Sequence the conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= C_IDLE;
			bits_q  <= '0;
			ndig_q  <= '0;
		end else if (ctrl.start) begin
			phase_q <= C_SHIFT;
			bits_q  <= BW'(VALUE_BITS);
		end else begin
			case (phase_q)
				C_SHIFT: begin
					bits_q <= bits_q - BW'(1);
					if (bits_q == BW'(1)) begin
						phase_q <= C_NORM;
						ndig_q  <= NW'(NDIG);
					end
				end
				C_NORM: begin
					if (norm_shift) begin
						ndig_q <= ndig_q - NW'(1);
					end else begin
						phase_q <= C_DONE;
					end
				end
				C_IDLE, C_DONE: begin
					phase_q <= phase_q;
				end
				default: begin
					phase_q <= C_IDLE;
				end
			endcase
		end
	end

	// Hold the value and the digit slots
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			value_q <= value;
			radix_q <= radix;
			for (int i = 0; i < NDIG; i++) begin
				slot_q[i] <= 4'd0;
			end
		end else if (phase_q == C_SHIFT) begin
			value_q <= {value_q[VALUE_BITS-2:0], 1'b0};
			for (int i = 0; i < NDIG; i++) begin
				slot_q[i] <= shifted[i];
			end
		end else if (norm_shift || (phase_q == C_DONE && ctrl.pop)) begin
			slot_q[0] <= 4'd0;
			for (int i = 1; i < NDIG; i++) begin
				slot_q[i] <= slot_q[i-1];
			end
		end
	end

	assign stat.done      = (phase_q == C_DONE);
	assign stat.top_digit = slot_q[NDIG-1];
	assign ndig           = ndig_q;

endmodule
`default_nettype wire

// File: sv/integer_field_formatter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_field_formatter_unit
// printf-style integer conversion: turns a magnitude, sign and flags into the
// ASCII characters of the padded field.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one conversion request per transaction (magnitude, sign flag,
//            radix and the printf flags). Taken only while the unit is idle.
//   result : one character per transaction, last_char set on the final one.
//            A field with nothing to print sends no transaction at all.
// Sequence per item:
//   the value is shifted bit by bit through the digit chain, leading zero
//   digits are dropped, the segments of the field are handed over and sized,
//   then the characters are sent segment by segment, and each of the six
//   segments is closed once its count is spent. A new item is taken only
//   when the unit is back in idle after the last segment closes.
// Stalls: while result.ready is low the character stays in the output
//   register and the sequencer waits; nothing is lost or repeated.
// Reset: arst_n returns the unit to idle and empties the output register.
// ----------------------------------------------------------------------------
module integer_field_formatter_unit #(
	parameter int VALUE_BITS = 64,
	parameter int MAX_FIELD  = 64
) (
	input wire           clk,
	input wire           arst_n,
	iff_item_if.sink     item,
	iff_result_if.source result
);

	localparam int NDIG   = (VALUE_BITS + 2) / 3;
	localparam int NW     = $clog2(NDIG + 1);
	localparam int CW     = iff_pkg::CNT_W;
	localparam int WCLAMP = (MAX_FIELD < 127) ? MAX_FIELD : 127;
	localparam int PCLAMP = (MAX_FIELD - 3 < 63) ? MAX_FIELD - 3 : 63;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_CALC = 4'b0100,
		S_EMIT = 4'b1000
	} fmt_state_t;

	fmt_state_t          state_q;
	iff_pkg::conv_ctrl_t conv_ctrl;
	iff_pkg::conv_stat_t conv_stat;
	logic [NW-1:0]       conv_ndig;

	// Flags held for the current item
	logic       nsign_q;
	logic [7:0] sign_ch_q;
	logic       oct_q;
	logic       hex_q;
	logic       upper_q;
	logic       left_q;
	logic       zpad_q;
	logic       alt_q;
	logic       hasprec_q;
	logic       nz_q;
	logic       pre_hex_q;
	logic [6:0] width_q;
	logic [5:0] prec_q;

	// Segment counters
	logic [CW-1:0] cnt_q [iff_pkg::SEG_N];
	logic [2:0]    seg_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;

	logic item_acc;
	logic load_out;
	logic later_nz;
	logic [CW-1:0] cur_cnt;
	logic [7:0]    next_char;

	// Field sizing
	logic [CW-1:0] nd_c;
	logic [CW-1:0] prec_c;
	logic [CW-1:0] nzero_c;
	logic [1:0]    npre_c;
	logic [CW-1:0] body_c;
	logic [CW-1:0] width_c;
	logic [CW-1:0] pad_c;
	logic          zfill_c;

	assign item_acc  = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);

	iff_digit_conv #(
		.VALUE_BITS(VALUE_BITS)
	) u_conv (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (conv_ctrl),
		.value (item.magnitude[VALUE_BITS-1:0]),
		.radix (item.radix_select),
		.stat  (conv_stat),
		.ndig  (conv_ndig)
	);

	assign conv_ctrl.start = item_acc;
	assign conv_ctrl.pop   = load_out && (seg_q == iff_pkg::SEG_DIGIT);

	// Size the segments of the field
	always_comb begin
		if (hasprec_q && prec_q == 6'd0 && !nz_q) begin
			nd_c = '0;
		end else begin
			nd_c = CW'(conv_ndig);
		end
		prec_c = CW'(prec_q);
		if (hasprec_q && prec_c > nd_c) begin
			nzero_c = prec_c - nd_c;
		end else begin
			nzero_c = '0;
		end
		if (alt_q && hex_q && nz_q) begin
			npre_c = 2'd2;
		end else if (alt_q && oct_q && nzero_c == '0 && (nd_c == '0 || nz_q)) begin
			npre_c = 2'd1;
		end else begin
			npre_c = 2'd0;
		end
		body_c  = CW'(nsign_q) + CW'(npre_c) + nzero_c + nd_c;
		width_c = CW'(width_q);
		if (width_c > body_c) begin
			pad_c = width_c - body_c;
		end else begin
			pad_c = '0;
		end
		zfill_c = !left_q && zpad_q && !hasprec_q;
	end

	// Pick the character of the current segment
	always_comb begin
		cur_cnt = cnt_q[seg_q];
		case (seg_q)
			iff_pkg::SEG_SIGN: begin
				next_char = sign_ch_q;
			end
			iff_pkg::SEG_PREFIX: begin
				if (pre_hex_q && cur_cnt == CW'(1)) begin
					next_char = upper_q ? iff_pkg::CH_X_UP : iff_pkg::CH_X_LO;
				end else begin
					next_char = iff_pkg::CH_ZERO;
				end
			end
			iff_pkg::SEG_ZERO: begin
				next_char = iff_pkg::CH_ZERO;
			end
			iff_pkg::SEG_DIGIT: begin
				next_char = iff_pkg::digit_char(conv_stat.top_digit, upper_q);
			end
			default: begin
				next_char = iff_pkg::CH_BLANK;
			end
		endcase
		later_nz = 1'b0;
		for (int i = 0; i < iff_pkg::SEG_N; i++) begin
			if (3'(i) > seg_q && cnt_q[i] != '0) begin
				later_nz = 1'b1;
			end
		end
	end

	assign load_out = (state_q == S_EMIT) && (cur_cnt != '0)
		&& (!out_valid_q || result.ready);

	// Sequence one item through conversion, sizing and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seg_q   <= iff_pkg::SEG_LEAD;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (conv_stat.done) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					seg_q   <= iff_pkg::SEG_LEAD;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (cur_cnt == '0) begin
						if (seg_q == iff_pkg::SEG_TRAIL) begin
							state_q <= S_IDLE;
						end else begin
							seg_q <= seg_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture flags and count down the segments
	always_ff @(posedge clk) begin
		if (item_acc) begin
			upper_q   <= item.upper_case;
			left_q    <= item.align_left;
			zpad_q    <= item.pad_zero;
			alt_q     <= item.alt_form;
			hasprec_q <= item.precision_given;
			oct_q     <= (item.radix_select == iff_pkg::RADIX_OCT);
			hex_q     <= (item.radix_select != iff_pkg::RADIX_OCT)
				&& (item.radix_select != iff_pkg::RADIX_DEC);
			nz_q      <= |item.magnitude[VALUE_BITS-1:0];
			nsign_q   <= item.is_negative || item.plus_sign || item.blank_sign;
			if (item.is_negative) begin
				sign_ch_q <= iff_pkg::CH_MINUS;
			end else if (item.plus_sign) begin
				sign_ch_q <= iff_pkg::CH_PLUS;
			end else begin
				sign_ch_q <= iff_pkg::CH_BLANK;
			end
			width_q <= (item.field_width > 7'(WCLAMP)) ? 7'(WCLAMP) : item.field_width;
			prec_q  <= (item.min_digits > 6'(PCLAMP)) ? 6'(PCLAMP) : item.min_digits;
		end
		if (state_q == S_CALC) begin
			cnt_q[iff_pkg::SEG_LEAD]   <= (!left_q && !zfill_c) ? pad_c : '0;
			cnt_q[iff_pkg::SEG_SIGN]   <= CW'(nsign_q);
			cnt_q[iff_pkg::SEG_PREFIX] <= CW'(npre_c);
			cnt_q[iff_pkg::SEG_ZERO]   <= nzero_c + (zfill_c ? pad_c : '0);
			cnt_q[iff_pkg::SEG_DIGIT]  <= nd_c;
			cnt_q[iff_pkg::SEG_TRAIL]  <= left_q ? pad_c : '0;
			pre_hex_q <= (npre_c == 2'd2);
		end else if (load_out) begin
			cnt_q[seg_q] <= cur_cnt - CW'(1);
		end
	end

	// Hold the character until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= next_char;
			out_last_q <= (cur_cnt == CW'(1)) && !later_nz;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_char  = out_char_q;
	assign result.last_char = out_last_q;

endmodule
`default_nettype wire
